/* rtl/core/pts_pkg.sv */
// shared types and constants of the tone sequencer
`timescale 1ns / 1ps
package pts_pkg;

  localparam int TRACKS_DEF     = 4;
  localparam int ENTRIES_DEF    = 64;
  localparam int SLOTS_DEF      = 256;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int TRACK_IW = 3;
  localparam int NOTE_W   = 62;
  localparam int SUM_W    = 20;

  localparam logic [15:0] SLOT_LENGTH_RST = 16'd9000;
  localparam logic [8:0]  SONG_LENGTH_RST = 9'd128;

  localparam logic [0:0] CFG_SLOT_LENGTH = 1'b0;
  localparam logic [0:0] CFG_SONG_LENGTH = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  track;
    logic [5:0]  entry;
    logic [7:0]  begin_slot;
    logic [7:0]  end_slot;
    logic [30:0] phase_step;
    logic [14:0] amplitude;
  } req_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         slot;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PHASE,
    S_ROM,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TRACK_IW-1:0] track;
    logic                clr_sum;
    logic                set_active;
    logic [30:0]         step;
    logic [14:0]         amp;
    logic                adv_phase;
    logic                rom_rd;
    logic                mul_en;
    logic                acc_en;
  } ctl_t;

endpackage

/* rtl/core/pts_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pts_synth.sv */
// per-track phase, shared sine lookup, multiplier and accumulator
`timescale 1ns / 1ps
module pts_synth #(
  parameter int TRACKS     = pts_pkg::TRACKS_DEF,
  parameter int SINE_DEPTH = pts_pkg::SINE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pts_pkg::ctl_t                      ctl,
  output logic signed [pts_pkg::SUM_W-1:0]   sum
);

  localparam int TIW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW  = $clog2(SINE_DEPTH);
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef logic signed [15:0] rom_t [SINE_DEPTH];

  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] v;
    logic neg;
    x = (64'd2 * PI_Q30 * 64'(k)) / SINE_DEPTH;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      neg = 1'b1;
      x = x - PI_Q30;
    end
    if (x > (PI_Q30 >> 1)) x = PI_Q30 - x;
    term = x;
    acc = $signed(x);
    term = (((term * x) >> 30) * x) >> 30; term = term / 6;   acc = acc - $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 20;  acc = acc + $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 42;  acc = acc - $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 72;  acc = acc + $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 110; acc = acc - $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 156; acc = acc + $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 210; acc = acc - $signed(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 272; acc = acc + $signed(term);
    if (acc < 0) acc = 0;
    if (acc > $signed(ONE_Q30)) acc = $signed(ONE_Q30);
    v = (64'(acc) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return neg ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
      r[k] = sine_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [31:0]        phase   [TRACKS];
  logic [30:0]        act_step[TRACKS];
  logic [14:0]        act_amp [TRACKS];
  logic [SW-1:0]      rom_idx;
  logic signed [15:0] sine_q;
  logic signed [31:0] prod;
  logic [31:0]        phase_next;
  logic [TIW-1:0]     t;

  assign t = ctl.track[TIW-1:0];
  assign phase_next = phase[t] + {1'b0, act_step[t]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) begin
        phase[i]    <= '0;
        act_step[i] <= '0;
        act_amp[i]  <= '0;
      end
      sum <= '0;
    end else begin
      if (ctl.set_active) begin
        act_step[t] <= ctl.step;
        act_amp[t]  <= ctl.amp;
      end
      if (ctl.adv_phase) begin
        phase[t] <= phase_next;
      end
      if (ctl.clr_sum) begin
        sum <= '0;
      end else if (ctl.acc_en) begin
        sum <= sum + {{(pts_pkg::SUM_W-17){prod[31]}}, prod[31:15]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_phase) rom_idx <= phase_next[31 -: SW];
    if (ctl.rom_rd)    sine_q  <= SINE_ROM[rom_idx];
    if (ctl.mul_en)    prod    <= sine_q * $signed({1'b0, act_amp[t]});
  end

endmodule

/* rtl/core/polyphonic_tone_sequencer.sv */
// top level: note table, search and sample sequencer, output register
// a load is written to the note table when taken; a tick searches the note table
// at a slot start, then runs phase, sine lookup, multiply and accumulate for each
// track in turn and registers the response
// no request is taken while a tick is in progress; a held response holds the next tick at its end
// rst is synchronous: note table reads as zero, phases, slot and config reset
`timescale 1ns / 1ps
module polyphonic_tone_sequencer #(
  parameter int TRACKS     = pts_pkg::TRACKS_DEF,
  parameter int ENTRIES    = pts_pkg::ENTRIES_DEF,
  parameter int SLOTS      = pts_pkg::SLOTS_DEF,
  parameter int SINE_DEPTH = pts_pkg::SINE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pts_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int DEPTH = TRACKS * ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(TRACKS + 1);
  localparam int EW    = $clog2(ENTRIES + 1);
  localparam int EIW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  pts_pkg::state_t state, state_next;
  pts_pkg::ctl_t   ctl;

  logic [15:0] slot_length;
  logic [8:0]  song_length;
  logic [7:0]  cur_slot;
  logic [15:0] sample_count;
  logic [TW-1:0] t_cnt, t_cnt_next;
  logic [EW-1:0] e_cnt, e_cnt_next;
  logic          pend, pend_next;
  logic [DEPTH-1:0] vld;
  logic          vld_q;
  logic [pts_pkg::NOTE_W-1:0] rdata;
  logic [AW-1:0] waddr, raddr;
  logic          wr_ok, we;
  logic          accept;
  logic          match;
  logic [7:0]    n_begin, n_end;
  logic signed [pts_pkg::SUM_W-1:0] sum;
  logic signed [15:0] sat;
  logic          done_go;
  logic [8:0]    slot_inc;

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != pts_pkg::S_IDLE);

  assign wr_ok = (32'(req.track) < TRACKS) && (32'(req.entry) < ENTRIES);
  assign we    = accept && (req.cmd == pts_pkg::CMD_LOAD) && wr_ok;
  assign waddr = AW'(32'(req.track) * ENTRIES + 32'(req.entry));
  assign raddr = AW'(32'(t_cnt) * ENTRIES + 32'(e_cnt[EIW-1:0]));

  pts_ram #(.WIDTH(pts_pkg::NOTE_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({req.begin_slot, req.end_slot, req.phase_step, req.amplitude}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
    vld_q <= vld[raddr];
  end

  // an entry never loaded is all zero: slot zero only, silent
  assign n_begin = vld_q ? rdata[61:54] : 8'd0;
  assign n_end   = vld_q ? rdata[53:46] : 8'd0;
  assign match   = (cur_slot >= n_begin) && (cur_slot <= n_end);

  pts_synth #(.TRACKS(TRACKS), .SINE_DEPTH(SINE_DEPTH)) u_synth (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sum (sum)
  );

  always_comb begin
    if (sum > 20'sd32767) sat = 16'sd32767;
    else if (sum < -20'sd32768) sat = -16'sd32768;
    else sat = sum[15:0];
  end

  assign done_go  = (state == pts_pkg::S_DONE) && (!rsp_valid || !rsp_stall);
  assign slot_inc = {1'b0, cur_slot} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::S_IDLE;
      t_cnt <= '0;
      e_cnt <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      t_cnt <= t_cnt_next;
      e_cnt <= e_cnt_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    t_cnt_next = t_cnt;
    e_cnt_next = e_cnt;
    pend_next  = pend;
    ctl = '0;
    ctl.track = pts_pkg::TRACK_IW'(t_cnt);
    unique case (state)
      pts_pkg::S_IDLE: begin
        if (accept && req.cmd == pts_pkg::CMD_TICK) begin
          ctl.clr_sum = 1'b1;
          t_cnt_next  = '0;
          e_cnt_next  = '0;
          pend_next   = 1'b0;
          state_next  = (sample_count == 16'd0) ? pts_pkg::S_SEARCH : pts_pkg::S_PHASE;
        end
      end
      pts_pkg::S_SEARCH: begin
        if (pend && match) begin
          ctl.set_active = 1'b1;
          ctl.step = vld_q ? rdata[45:15] : 31'd0;
          ctl.amp  = vld_q ? rdata[14:0] : 15'd0;
          pend_next  = 1'b0;
          e_cnt_next = '0;
          t_cnt_next = t_cnt + 1'b1;
          if (32'(t_cnt) == TRACKS - 1) begin
            t_cnt_next = '0;
            state_next = pts_pkg::S_PHASE;
          end
        end else if (32'(e_cnt) < ENTRIES) begin
          e_cnt_next = e_cnt + 1'b1;
          pend_next  = 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          ctl.set_active = 1'b1;
          e_cnt_next = '0;
          t_cnt_next = t_cnt + 1'b1;
          if (32'(t_cnt) == TRACKS - 1) begin
            t_cnt_next = '0;
            state_next = pts_pkg::S_PHASE;
          end
        end
      end
      pts_pkg::S_PHASE: begin
        ctl.adv_phase = 1'b1;
        state_next = pts_pkg::S_ROM;
      end
      pts_pkg::S_ROM: begin
        ctl.rom_rd = 1'b1;
        state_next = pts_pkg::S_MUL;
      end
      pts_pkg::S_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = pts_pkg::S_ACC;
      end
      pts_pkg::S_ACC: begin
        ctl.acc_en = 1'b1;
        if (32'(t_cnt) == TRACKS - 1) begin
          t_cnt_next = '0;
          state_next = pts_pkg::S_DONE;
        end else begin
          t_cnt_next = t_cnt + 1'b1;
          state_next = pts_pkg::S_PHASE;
        end
      end
      pts_pkg::S_DONE: begin
        if (done_go) state_next = pts_pkg::S_IDLE;
      end
      default: state_next = pts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_length  <= pts_pkg::SLOT_LENGTH_RST;
      song_length  <= pts_pkg::SONG_LENGTH_RST;
      cur_slot     <= '0;
      sample_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pts_pkg::CFG_SLOT_LENGTH: slot_length <= cfg_data;
          pts_pkg::CFG_SONG_LENGTH: song_length <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (done_go) begin
        rsp_valid <= 1'b1;
        if (17'(sample_count) + 17'd1 >= 17'(slot_length)) begin
          sample_count <= '0;
          if (slot_inc >= song_length || 32'(slot_inc) >= SLOTS) cur_slot <= '0;
          else cur_slot <= slot_inc[7:0];
        end else begin
          sample_count <= sample_count + 16'd1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      rsp.sample <= sat;
      rsp.slot   <= cur_slot;
    end
  end

endmodule

/* rtl/core/pts_checker.sv */
// port checker for the tone sequencer, bound to the top level
`timescale 1ns / 1ps
module pts_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input pts_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pts_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response after reset");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.cmd == pts_pkg::CMD_LOAD && !rsp_valid |=> !rsp_valid)
    else $error("load request produced a response");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.cmd == pts_pkg::CMD_TICK |=> req_stall)
    else $error("request taken during a tick");

endmodule

bind polyphonic_tone_sequencer pts_checker u_pts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
